// ===== rtl/core/swls_pkg.sv =====
// ----------------------------------------------------------------------------
// Stopwatch lap/split package
// Shared types, codes and constants for the stopwatch lap/split controller.
// ----------------------------------------------------------------------------
package swls_pkg;

  typedef enum logic [1:0] {
    EV_TICK      = 2'd0,
    EV_STARTSTOP = 2'd1,
    EV_LAP       = 2'd2,
    EV_SLOW      = 2'd3
  } event_e;

  typedef enum logic [2:0] {
    ST_IDLE     = 3'd0,
    ST_RUN      = 3'd1,
    ST_RUN_LAP  = 3'd2,
    ST_STOP     = 3'd3,
    ST_STOP_LAP = 3'd4
  } status_e;

  typedef enum logic {
    REG_FAST_RATE = 1'b0,
    REG_SLOW_RATE = 1'b1
  } reg_e;

  localparam logic [7:0] FAST_RATE_RESET = 8'd32;
  localparam logic [7:0] SLOW_RATE_RESET = 8'd2;
  localparam logic [7:0] RATE_MIN        = 8'd1;
  localparam logic [7:0] RATE_MAX        = 8'd128;
  localparam logic [7:0] LAP_RATE        = 8'd2;
  localparam logic [7:0] IDLE_RATE       = 8'd1;
  localparam logic [6:0] HALF_SEC_TICKS  = 7'd64;

  localparam int TICK_W          = 32;
  localparam int SUBSEC_W        = 7;
  localparam int SECS_W          = TICK_W - SUBSEC_W;
  localparam int MINS_W          = 20;
  localparam int HOURS_W         = 14;
  localparam int DAYS_W          = 9;
  localparam int SECS_PER_MIN    = 60;
  localparam int MINS_PER_HOUR   = 60;
  localparam int HOURS_PER_DAY   = 24;
  localparam int MINS_PER_DAY    = MINS_PER_HOUR * HOURS_PER_DAY;
  localparam int HUNDREDTHS      = 100;

  // Reciprocals for exact floor division over the full input range.
  localparam int SEC_DIV_SHIFT   = 31;
  localparam int SEC_RECIP_W     = 26;
  localparam logic [SEC_RECIP_W-1:0] SEC_RECIP =
    SEC_RECIP_W'((64'd1 << SEC_DIV_SHIFT) / 64'(SECS_PER_MIN) + 64'd1);
  localparam int MIN_DIV_SHIFT   = 26;
  localparam int MIN_RECIP_W     = 21;
  localparam logic [MIN_RECIP_W-1:0] MIN_RECIP =
    MIN_RECIP_W'((64'd1 << MIN_DIV_SHIFT) / 64'(MINS_PER_HOUR) + 64'd1);
  localparam int DAY_DIV_SHIFT   = 31;
  localparam logic [MIN_RECIP_W-1:0] DAY_RECIP =
    MIN_RECIP_W'((64'd1 << DAY_DIV_SHIFT) / 64'(MINS_PER_DAY) + 64'd1);

  typedef struct packed {
    logic [1:0]  mode;
    logic [31:0] counter_value;
    logic [6:0]  tick_phase;
  } in_word_t;

  typedef struct packed {
    logic [31:0] elapsed_ticks;
    logic [6:0]  hundredths;
    logic [5:0]  seconds_part;
    logic [5:0]  minutes_part;
    logic [4:0]  hours_part;
    logic [2:0]  run_status;
    logic [7:0]  refresh_hz;
    logic        lap_lamp;
    logic        colon_lamp;
    logic        blank_hundredths;
    logic        exit_to_clock;
  } out_word_t;

  typedef struct packed {
    logic [TICK_W-1:0] elapsed;
    status_e           status;
    logic [7:0]        refresh;
    logic              lap;
    logic              colon;
    logic              blank;
    logic              leave;
  } stage_a_t;

  typedef struct packed {
    stage_a_t          head;
    logic [6:0]        hundredths;
    logic [5:0]        seconds_part;
    logic [MINS_W-1:0] minutes_total;
  } stage_b_t;

endpackage

// ===== rtl/core/stopwatch_lap_split_controller.sv =====
// ----------------------------------------------------------------------------
// Stopwatch lap/split controller
// Five-state stopwatch with lap freeze, driven by time-stamped events, with
// an APB-style port for the two refresh rate registers.
// ----------------------------------------------------------------------------
//   Channel   Direction  Handshake                 Word
//   in        input      in_valid_i / in_stall_o   mode, counter_value, tick_phase
//   out       output     out_valid_o / out_stall_i elapsed time parts, status, lamps
//   apb       input      psel, penable, pready     refresh rate registers
//
// One event is accepted per cycle while the input is not stalled; its result
// passes through the state update stage and two time splitting stages.
// Reset clears the stopwatch to idle and loads the default refresh rates.
// A stalled result holds its stage, and the input stalls only once all three
// stages are full.
module stopwatch_lap_split_controller (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  swls_pkg::in_word_t  in_word_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output swls_pkg::out_word_t out_word_o,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [2:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready
);
  import swls_pkg::*;

  logic [7:0] fast_rate_q, slow_rate_q;
  logic [7:0] wr_rate;
  logic       cfg_write;
  reg_e       reg_sel;
  logic       a_valid, a_stall;
  stage_a_t   a_word;

  assign pready    = 1'b1;
  assign reg_sel   = reg_e'(paddr[2]);
  assign cfg_write = psel && penable && pwrite && pready;

  always_comb begin
    if (pwdata[7:0] == 8'd0) begin
      wr_rate = RATE_MIN;
    end else if (pwdata[7:0] > RATE_MAX) begin
      wr_rate = RATE_MAX;
    end else begin
      wr_rate = pwdata[7:0];
    end
  end

  always_comb begin
    unique case (reg_sel)
      REG_FAST_RATE: prdata = {24'd0, fast_rate_q};
      REG_SLOW_RATE: prdata = {24'd0, slow_rate_q};
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fast_rate_q <= FAST_RATE_RESET;
      slow_rate_q <= SLOW_RATE_RESET;
    end else if (cfg_write) begin
      if (reg_sel == REG_FAST_RATE) begin
        fast_rate_q <= wr_rate;
      end else begin
        slow_rate_q <= wr_rate;
      end
    end
  end

  swls_fsm u_fsm (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_word_i   (in_word_i),
    .fast_rate_i (fast_rate_q),
    .slow_rate_i (slow_rate_q),
    .a_valid_o   (a_valid),
    .a_word_o    (a_word),
    .a_stall_i   (a_stall)
  );

  swls_time u_time (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .a_valid_i   (a_valid),
    .a_word_i    (a_word),
    .a_stall_o   (a_stall),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_word_o  (out_word_o)
  );

`ifndef NO_ASSERTIONS
  a_stall_needs_word: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> a_valid)
    else $error("input stalled with an empty state update stage");

  a_stall_from_output: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (out_valid_o && out_stall_i))
    else $error("input stalled without output backpressure");

  a_rate_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_write |=> (fast_rate_q >= RATE_MIN && fast_rate_q <= RATE_MAX &&
                   slow_rate_q >= RATE_MIN && slow_rate_q <= RATE_MAX))
    else $error("refresh rate register out of range after write");
`endif

endmodule

// ===== rtl/core/swls_fsm.sv =====
// ----------------------------------------------------------------------------
// Stopwatch lap/split state machine
// Applies one event per cycle, unless the next stage stalls, to the stopwatch
// state and registers the shown elapsed ticks together with status, refresh rate, lamp, blank and leave flags.
// ----------------------------------------------------------------------------
module swls_fsm (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  swls_pkg::in_word_t in_word_i,
  input  logic [7:0]         fast_rate_i,
  input  logic [7:0]         slow_rate_i,
  output logic               a_valid_o,
  output swls_pkg::stage_a_t a_word_o,
  input  logic               a_stall_i
);
  import swls_pkg::*;

  status_e           status_q, status_d;
  logic [TICK_W-1:0] start_q, start_d;
  logic [TICK_W-1:0] stop_q, stop_d;
  logic [TICK_W-1:0] lap_q, lap_d;
  logic              slow_q, slow_d;
  logic              leave;
  logic              accept;
  logic              a_valid_q;
  stage_a_t          a_word_q, a_word_d;
  event_e            ev;
  logic [TICK_W-1:0] now;

  assign ev         = event_e'(in_word_i.mode);
  assign now        = in_word_i.counter_value;
  assign in_stall_o = a_valid_q && a_stall_i;
  assign accept     = in_valid_i && !in_stall_o;
  assign a_valid_o  = a_valid_q;
  assign a_word_o   = a_word_q;

  always_comb begin
    status_d = status_q;
    start_d  = start_q;
    stop_d   = stop_q;
    lap_d    = lap_q;
    slow_d   = slow_q;
    leave    = 1'b0;
    unique case (status_q)
      ST_IDLE: begin
        if (ev == EV_STARTSTOP) begin
          status_d = ST_RUN;
          start_d  = now;
        end else if (ev == EV_SLOW) begin
          slow_d = !slow_q;
        end
      end
      ST_RUN: begin
        if (ev == EV_STARTSTOP) begin
          status_d = ST_STOP;
          stop_d   = now;
        end else if (ev == EV_LAP) begin
          status_d = ST_RUN_LAP;
          lap_d    = now;
        end
      end
      ST_RUN_LAP: begin
        if (ev == EV_STARTSTOP) begin
          status_d = ST_STOP_LAP;
          stop_d   = now;
        end else if (ev == EV_LAP) begin
          status_d = ST_RUN;
          lap_d    = now;
        end else if (ev == EV_SLOW) begin
          status_d = ST_RUN;
          slow_d   = !slow_q;
        end
      end
      ST_STOP_LAP: begin
        if (ev == EV_STARTSTOP) begin
          status_d = ST_RUN_LAP;
          start_d  = now - stop_q + start_q;
          lap_d    = now - stop_q + lap_q;
        end else if (ev == EV_LAP) begin
          status_d = ST_STOP;
        end
      end
      ST_STOP: begin
        if (ev == EV_STARTSTOP) begin
          status_d = ST_RUN;
          start_d  = now - stop_q + start_q;
        end else if (ev == EV_LAP) begin
          status_d = ST_IDLE;
          start_d  = '0;
          stop_d   = '0;
          lap_d    = '0;
          leave    = 1'b1;
        end
      end
      default: begin
      end
    endcase

    a_word_d        = '0;
    a_word_d.status = status_d;
    a_word_d.leave  = leave;
    a_word_d.blank  = slow_d && (status_d == ST_RUN || status_d == ST_IDLE);
    a_word_d.lap    = 1'b0;
    a_word_d.colon  = 1'b1;
    a_word_d.refresh = IDLE_RATE;
    case (status_d)
      ST_RUN: begin
        a_word_d.elapsed = now - start_d;
        a_word_d.refresh = slow_d ? slow_rate_i : fast_rate_i;
        a_word_d.colon   = (a_word_d.elapsed[SUBSEC_W-1:0] < HALF_SEC_TICKS);
      end
      ST_RUN_LAP: begin
        a_word_d.elapsed = lap_d - start_d;
        a_word_d.refresh = LAP_RATE;
        a_word_d.lap     = (in_word_i.tick_phase == '0);
        a_word_d.colon   = (in_word_i.tick_phase == '0);
      end
      ST_STOP_LAP: begin
        a_word_d.elapsed = lap_d - start_d;
        a_word_d.lap     = 1'b1;
      end
      ST_STOP: begin
        a_word_d.elapsed = stop_d - start_d;
      end
      default: begin
        a_word_d.elapsed = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      status_q <= ST_IDLE;
      start_q  <= '0;
      stop_q   <= '0;
      lap_q    <= '0;
      slow_q   <= 1'b0;
    end else if (accept) begin
      status_q <= status_d;
      start_q  <= start_d;
      stop_q   <= stop_d;
      lap_q    <= lap_d;
      slow_q   <= slow_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
    end else if (!in_stall_o) begin
      a_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      a_word_q <= a_word_d;
    end
  end

endmodule

// ===== rtl/core/swls_time.sv =====
// ----------------------------------------------------------------------------
// Stopwatch lap/split time splitter
// Two pipeline stages that break elapsed ticks into hundredths, seconds,
// minutes and hours, ending in the result register.
// ----------------------------------------------------------------------------
module swls_time (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                a_valid_i,
  input  swls_pkg::stage_a_t  a_word_i,
  output logic                a_stall_o,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output swls_pkg::out_word_t out_word_o
);
  import swls_pkg::*;

  localparam int SEC_PROD_W  = SECS_W + SEC_RECIP_W;
  localparam int MIN_PROD_W  = MINS_W + MIN_RECIP_W;
  localparam int HUND_PROD_W = SUBSEC_W + 7;

  logic                   b_valid_q, b_stall;
  stage_b_t               b_word_q, b_word_d;
  logic                   out_valid_q;
  out_word_t              out_word_q, out_word_d;

  logic [SECS_W-1:0]      secs, secs_rem;
  logic [SEC_PROD_W-1:0]  sec_prod;
  logic [MINS_W-1:0]      mins;
  logic [HUND_PROD_W-1:0] hund_prod;

  logic [MIN_PROD_W-1:0]  hour_prod, day_prod;
  logic [HOURS_W-1:0]     hours, hours_rem;
  logic [DAYS_W-1:0]      days;
  logic [MINS_W-1:0]      mins_rem;

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_word_q;
  assign b_stall     = out_valid_q && out_stall_i;
  assign a_stall_o   = b_valid_q && b_stall;

  always_comb begin
    secs      = a_word_i.elapsed[TICK_W-1:SUBSEC_W];
    sec_prod  = SEC_PROD_W'(secs) * SEC_PROD_W'(SEC_RECIP);
    mins      = sec_prod[SEC_DIV_SHIFT +: MINS_W];
    secs_rem  = secs - SECS_W'(mins) * SECS_W'(SECS_PER_MIN);
    hund_prod = HUND_PROD_W'(a_word_i.elapsed[SUBSEC_W-1:0]) * HUND_PROD_W'(HUNDREDTHS);

    b_word_d               = '0;
    b_word_d.head          = a_word_i;
    b_word_d.hundredths    = hund_prod[HUND_PROD_W-1:SUBSEC_W];
    b_word_d.seconds_part  = secs_rem[5:0];
    b_word_d.minutes_total = mins;
  end

  always_comb begin
    hour_prod = MIN_PROD_W'(b_word_q.minutes_total) * MIN_PROD_W'(MIN_RECIP);
    day_prod  = MIN_PROD_W'(b_word_q.minutes_total) * MIN_PROD_W'(DAY_RECIP);
    hours     = hour_prod[MIN_DIV_SHIFT +: HOURS_W];
    days      = day_prod[DAY_DIV_SHIFT +: DAYS_W];
    mins_rem  = b_word_q.minutes_total - MINS_W'(hours) * MINS_W'(MINS_PER_HOUR);
    hours_rem = hours - HOURS_W'(days) * HOURS_W'(HOURS_PER_DAY);

    out_word_d                  = '0;
    out_word_d.elapsed_ticks    = b_word_q.head.elapsed;
    out_word_d.hundredths       = b_word_q.hundredths;
    out_word_d.seconds_part     = b_word_q.seconds_part;
    out_word_d.minutes_part     = mins_rem[5:0];
    out_word_d.hours_part       = hours_rem[4:0];
    out_word_d.run_status       = b_word_q.head.status;
    out_word_d.refresh_hz       = b_word_q.head.refresh;
    out_word_d.lap_lamp         = b_word_q.head.lap;
    out_word_d.colon_lamp       = b_word_q.head.colon;
    out_word_d.blank_hundredths = b_word_q.head.blank;
    out_word_d.exit_to_clock    = b_word_q.head.leave;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b_valid_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (!a_stall_o) begin
        b_valid_q <= a_valid_i;
      end
      if (!b_stall) begin
        out_valid_q <= b_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (a_valid_i && !a_stall_o) begin
      b_word_q <= b_word_d;
    end
    if (b_valid_q && !b_stall) begin
      out_word_q <= out_word_d;
    end
  end

endmodule

// ===== tb/stopwatch_lap_split_controller_tb.sv =====
// ----------------------------------------------------------------------------
// Stopwatch lap/split controller testbench
// Sends event words through the valid/stall input and follows each one with
// a model of the stopwatch held in the bench. Every result word is compared
// field by field with the oldest predicted one. The refresh rate registers
// are written over the APB port between phases, with clamping and read-back.
// Directed walks cover every state change. Random phases vary the idle
// pattern on both sides, and one receiver hold-off fills the pipeline.
// ----------------------------------------------------------------------------
module stopwatch_lap_split_controller_tb;
  import swls_pkg::*;

  localparam int QUIET_LIMIT = 2000;
  localparam int HOLD_CYCLES = 300;

  logic        clk_i;
  logic        rst_ni       = 1'b0;
  logic        in_valid_i   = 1'b0;
  logic        in_stall_o;
  in_word_t    in_word_i    = '0;
  logic        out_valid_o;
  logic        out_stall_i  = 1'b0;
  out_word_t   out_word_o;
  logic        psel         = 1'b0;
  logic        penable      = 1'b0;
  logic        pwrite       = 1'b0;
  logic [2:0]  paddr        = '0;
  logic [31:0] pwdata       = '0;
  logic [31:0] prdata;
  logic        pready;

  stopwatch_lap_split_controller i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_word_i   (in_word_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_word_o  (out_word_o),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready)
  );

  // Stopwatch state as the bench sees it.
  status_e     sw_status = ST_IDLE;
  logic [31:0] t_start   = '0;
  logic [31:0] t_stop    = '0;
  logic [31:0] t_lap     = '0;
  logic        slow_on   = 1'b0;
  logic [7:0]  fast_hz   = FAST_RATE_RESET;
  logic [7:0]  slow_hz   = SLOW_RATE_RESET;

  out_word_t   display_q[$];
  logic [31:0] clock_now      = '0;
  int          send_gap_pct   = 0;
  int          recv_stall_pct = 0;
  logic        rx_hold_req    = 1'b0;
  int          rx_hold_left   = 0;
  logic        in_take        = 1'b0;
  int          quiet_cycles   = 0;
  int          fail_cnt       = 0;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic out_word_t step_stopwatch(input in_word_t w);
    event_e      ev;
    logic [31:0] now;
    logic [31:0] el;
    logic [24:0] secs;
    logic [24:0] mins;
    logic        leave;
    out_word_t   r;
    ev    = event_e'(w.mode);
    now   = w.counter_value;
    leave = 1'b0;
    case (sw_status)
      ST_IDLE: begin
        if (ev == EV_STARTSTOP) begin
          sw_status = ST_RUN;
          t_start   = now;
        end else if (ev == EV_SLOW) begin
          slow_on = !slow_on;
        end
      end
      ST_RUN: begin
        if (ev == EV_STARTSTOP) begin
          sw_status = ST_STOP;
          t_stop    = now;
        end else if (ev == EV_LAP) begin
          sw_status = ST_RUN_LAP;
          t_lap     = now;
        end
      end
      ST_RUN_LAP: begin
        if (ev == EV_STARTSTOP) begin
          sw_status = ST_STOP_LAP;
          t_stop    = now;
        end else if (ev == EV_LAP) begin
          sw_status = ST_RUN;
          t_lap     = now;
        end else if (ev == EV_SLOW) begin
          sw_status = ST_RUN;
          slow_on   = !slow_on;
        end
      end
      ST_STOP_LAP: begin
        if (ev == EV_STARTSTOP) begin
          sw_status = ST_RUN_LAP;
          t_start   = now - t_stop + t_start;
          t_lap     = now - t_stop + t_lap;
        end else if (ev == EV_LAP) begin
          sw_status = ST_STOP;
        end
      end
      ST_STOP: begin
        if (ev == EV_STARTSTOP) begin
          sw_status = ST_RUN;
          t_start   = now - t_stop + t_start;
        end else if (ev == EV_LAP) begin
          sw_status = ST_IDLE;
          t_start   = '0;
          t_stop    = '0;
          t_lap     = '0;
          leave     = 1'b1;
        end
      end
      default: begin
      end
    endcase

    case (sw_status)
      ST_RUN:                  el = now - t_start;
      ST_RUN_LAP, ST_STOP_LAP: el = t_lap - t_start;
      ST_STOP:                 el = t_stop - t_start;
      default:                 el = '0;
    endcase
    secs = el[31:7];
    mins = secs / SECS_PER_MIN;

    r                  = '0;
    r.elapsed_ticks    = el;
    r.hundredths       = 7'((int'(el[6:0]) * HUNDREDTHS) / 128);
    r.seconds_part     = 6'(secs % SECS_PER_MIN);
    r.minutes_part     = 6'(mins % MINS_PER_HOUR);
    r.hours_part       = 5'((mins / MINS_PER_HOUR) % HOURS_PER_DAY);
    r.run_status       = sw_status;
    r.blank_hundredths = slow_on && (sw_status == ST_RUN || sw_status == ST_IDLE);
    r.exit_to_clock    = leave;
    case (sw_status)
      ST_RUN: begin
        r.refresh_hz = slow_on ? slow_hz : fast_hz;
        r.lap_lamp   = 1'b0;
        r.colon_lamp = (el[6:0] < HALF_SEC_TICKS);
      end
      ST_RUN_LAP: begin
        r.refresh_hz = LAP_RATE;
        r.lap_lamp   = (w.tick_phase == 7'd0);
        r.colon_lamp = (w.tick_phase == 7'd0);
      end
      ST_STOP_LAP: begin
        r.refresh_hz = IDLE_RATE;
        r.lap_lamp   = 1'b1;
        r.colon_lamp = 1'b1;
      end
      default: begin
        r.refresh_hz = IDLE_RATE;
        r.lap_lamp   = 1'b0;
        r.colon_lamp = 1'b1;
      end
    endcase
    return r;
  endfunction

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (got !== want) begin
      $error("%s mismatch: expected %0d, actual %0d", name, want, got);
      fail_cnt++;
    end
  endtask

  // Both handshakes are sampled at the falling edge, where everything has
  // settled for the rising edge that follows.
  always @(negedge clk_i) begin
    out_word_t want;
    in_take = rst_ni && in_valid_i && !in_stall_o;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (display_q.size() == 0) begin
        $error("result word arrived with nothing expected");
        fail_cnt++;
      end else begin
        want = display_q.pop_front();
        check_field("elapsed_ticks", want.elapsed_ticks, out_word_o.elapsed_ticks);
        check_field("hundredths", want.hundredths, out_word_o.hundredths);
        check_field("seconds_part", want.seconds_part, out_word_o.seconds_part);
        check_field("minutes_part", want.minutes_part, out_word_o.minutes_part);
        check_field("hours_part", want.hours_part, out_word_o.hours_part);
        check_field("run_status", want.run_status, out_word_o.run_status);
        check_field("refresh_hz", want.refresh_hz, out_word_o.refresh_hz);
        check_field("lap_lamp", want.lap_lamp, out_word_o.lap_lamp);
        check_field("colon_lamp", want.colon_lamp, out_word_o.colon_lamp);
        check_field("blank_hundredths", want.blank_hundredths,
                    out_word_o.blank_hundredths);
        check_field("exit_to_clock", want.exit_to_clock, out_word_o.exit_to_clock);
      end
      quiet_cycles = 0;
    end else if (in_take || !rst_ni) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
    end
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    if (rx_hold_req) begin
      rx_hold_left = HOLD_CYCLES;
      rx_hold_req  = 1'b0;
    end
    if (rx_hold_left > 0) begin
      rx_hold_left--;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  task automatic send_word(input in_word_t w);
    while ($urandom_range(99) < send_gap_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_word_i  <= w;
    do @(posedge clk_i); while (!in_take);
    display_q.push_back(step_stopwatch(w));
  endtask

  task automatic send_event(input event_e ev, input logic [31:0] stamp,
                            input logic [6:0] phase);
    in_word_t w;
    w.mode          = ev;
    w.counter_value = stamp;
    w.tick_phase    = phase;
    send_word(w);
  endtask

  function automatic in_word_t random_word();
    in_word_t w;
    int       pick;
    pick = $urandom_range(99);
    if (pick < 35)      w.mode = EV_TICK;
    else if (pick < 62) w.mode = EV_STARTSTOP;
    else if (pick < 88) w.mode = EV_LAP;
    else                w.mode = EV_SLOW;
    pick = $urandom_range(99);
    if (pick < 8)       clock_now = $urandom();
    else if (pick < 12) clock_now = 32'hFFFF_FFFF - $urandom_range(2000);
    else                clock_now = clock_now + $urandom_range(400);
    w.counter_value = clock_now;
    w.tick_phase    = ($urandom_range(1) == 0) ? 7'd0 : 7'($urandom_range(127));
    return w;
  endfunction

  task automatic wait_drained();
    in_valid_i <= 1'b0;
    while (display_q.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic read_rate(input reg_e which);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= {which, 2'b00};
    @(posedge clk_i);
    penable <= 1'b1;
    @(negedge clk_i);
    if (which == REG_FAST_RATE) check_field("fast_refresh_rate", fast_hz, prdata[7:0]);
    else                        check_field("slow_refresh_rate", slow_hz, prdata[7:0]);
    @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic write_rate(input reg_e which, input logic [31:0] value);
    logic [7:0] held;
    held = value[7:0];
    if (held == 8'd0)         held = RATE_MIN;
    else if (held > RATE_MAX) held = RATE_MAX;
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {which, 2'b00};
    pwdata  <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    if (which == REG_FAST_RATE) fast_hz = held;
    else                        slow_hz = held;
    read_rate(which);
  endtask

  task automatic set_rates(input logic [31:0] fast_val, input logic [31:0] slow_val);
    wait_drained();
    write_rate(REG_FAST_RATE, fast_val);
    write_rate(REG_SLOW_RATE, slow_val);
  endtask

  task automatic test_register_defaults();
    read_rate(REG_FAST_RATE);
    read_rate(REG_SLOW_RATE);
  endtask

  task automatic test_directed_walk();
    send_gap_pct   = 20;
    recv_stall_pct = 20;
    send_event(EV_TICK,      32'h0000_0000, 7'd0);
    send_event(EV_SLOW,      32'hFFFF_FFFF, 7'd127);
    send_event(EV_LAP,       32'h0000_0005, 7'd0);
    send_event(EV_STARTSTOP, 32'hFFFF_FF00, 7'd0);
    send_event(EV_TICK,      32'h0000_0040, 7'd0);
    send_event(EV_TICK,      32'hFFFF_FEFF, 7'd127);
    send_event(EV_SLOW,      32'h0000_0100, 7'd0);
    send_event(EV_LAP,       32'h0000_1000, 7'd0);
    send_event(EV_TICK,      32'h0000_2000, 7'd0);
    send_event(EV_TICK,      32'h0000_2001, 7'd127);
    send_event(EV_LAP,       32'h0000_3000, 7'd1);
    send_event(EV_LAP,       32'h0000_3100, 7'd0);
    send_event(EV_SLOW,      32'h0000_3200, 7'd64);
    send_event(EV_LAP,       32'h0000_3300, 7'd0);
    send_event(EV_STARTSTOP, 32'h0000_4000, 7'd0);
    send_event(EV_SLOW,      32'h0000_4100, 7'd0);
    send_event(EV_STARTSTOP, 32'h0000_9000, 7'd42);
    send_event(EV_STARTSTOP, 32'h0000_A000, 7'd0);
    send_event(EV_LAP,       32'h0000_A100, 7'd0);
    send_event(EV_SLOW,      32'h0000_A200, 7'd0);
    send_event(EV_STARTSTOP, 32'h0000_B000, 7'd0);
    send_event(EV_STARTSTOP, 32'h0000_C000, 7'd0);
    send_event(EV_TICK,      32'hFFFF_FFFF, 7'd127);
    send_event(EV_LAP,       32'h0000_D100, 7'd0);
    send_event(EV_SLOW,      32'h0000_D200, 7'd0);
  endtask

  task automatic test_random_events(input int count, input int gap_pct,
                                    input int stall_pct);
    send_gap_pct   = gap_pct;
    recv_stall_pct = stall_pct;
    repeat (count) send_word(random_word());
  endtask

  task automatic test_backpressure();
    send_gap_pct = 0;
    rx_hold_req  = 1'b1;
    repeat (40) send_word(random_word());
    wait_drained();
  endtask

  initial begin
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_register_defaults();
    test_directed_walk();
    set_rates(32'd1, 32'd128);
    test_random_events(650, 34, 70);
    set_rates(32'h0000_0100, 32'h0000_0181);
    test_random_events(650, 70, 34);
    set_rates(32'hFFFF_FF80, 32'd0);
    test_backpressure();
    set_rates($urandom(), $urandom_range(1, 128));
    test_random_events(600, 0, 0);

    wait_drained();
    repeat (8) @(posedge clk_i);
    if (display_q.size() != 0) begin
      $error("%0d result words never arrived", display_q.size());
      fail_cnt++;
    end
    if (fail_cnt == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/core/swls_pkg.sv
rtl/core/swls_fsm.sv
rtl/core/swls_time.sv
rtl/core/stopwatch_lap_split_controller.sv
tb/stopwatch_lap_split_controller_tb.sv
